// File: rtl/lpr_pkg.sv
// shared constants and types for the longest prefix route lookup
// no dependencies; imported by every module of the block
package lpr_pkg;

  localparam int DEF_ROUTE_SLOTS = 16;
  localparam int ADDR_W          = 32;
  localparam int SLOT_FIELD_W    = 4;
  localparam int PORT_FIELD_W    = 3;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // commands from the sequencer to the datapath
  typedef struct packed {
    logic wr_en;         // store a route word into its slot
    logic start_lookup;  // latch target, clear best match
    logic rd_en;         // read one slot at the scan index
  } lpr_cmd_t;

endpackage

// File: rtl/longest_prefix_route_lookup_top.sv
// top level of the ipv4 longest prefix route lookup
// depends on lpr_pkg, lpr_ctrl and lpr_datapath
//
// Route table of ROUTE_SLOTS slots with a command-style port. A word is taken
// on a clock edge with start high and busy low. A write word (op = 0) stores
// one slot at the edge that takes it and gives no result; the next word can
// follow at once. A lookup word (op = 1) raises busy while the slots are read
// one per cycle from the single read port of the route memory into a read
// register and compared against the target; the result then shows on hit,
// next_gateway, out_port and match_slot for exactly one cycle with done high.
// The receiver cannot stall: the result must be taken in that cycle. No word
// is taken while busy, but a new word may be started in the done cycle.
// Valid flags clear at reset; the slot contents need no clearing.
module longest_prefix_route_lookup_top import lpr_pkg::*; #(
  parameter int ROUTE_SLOTS = DEF_ROUTE_SLOTS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic                    op,
  input  logic [SLOT_FIELD_W-1:0] slot,
  input  logic [ADDR_W-1:0]       route_dest,
  input  logic [ADDR_W-1:0]       route_mask,
  input  logic [ADDR_W-1:0]       route_gateway,
  input  logic [PORT_FIELD_W-1:0] route_port,
  input  logic                    route_enable,
  input  logic [ADDR_W-1:0]       target_addr,
  output logic                    done,
  output logic                    hit,
  output logic [ADDR_W-1:0]       next_gateway,
  output logic [PORT_FIELD_W-1:0] out_port,
  output logic [SLOT_FIELD_W-1:0] match_slot
);

  localparam int SLOT_W = $clog2(ROUTE_SLOTS);

  lpr_cmd_t          cmd;
  logic [SLOT_W-1:0] rd_idx;

  // sequencer: word accept, scan counter, busy and done
  lpr_ctrl #(
    .ROUTE_SLOTS (ROUTE_SLOTS)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .op     (op),
    .busy   (busy),
    .done   (done),
    .cmd    (cmd),
    .rd_idx (rd_idx)
  );

  // route memory, valid flags and best-match tracking
  lpr_datapath #(
    .ROUTE_SLOTS (ROUTE_SLOTS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .rd_idx        (rd_idx),
    .slot          (slot),
    .route_dest    (route_dest),
    .route_mask    (route_mask),
    .route_gateway (route_gateway),
    .route_port    (route_port),
    .route_enable  (route_enable),
    .target_addr   (target_addr),
    .hit           (hit),
    .next_gateway  (next_gateway),
    .out_port      (out_port),
    .match_slot    (match_slot)
  );

  // a lookup word always starts a scan
  a_lookup_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && op == OP_LOOKUP) |=> busy)
    else $error("lookup word did not start a scan");

  // the end of a scan always delivers a result
  a_scan_done: assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && !$past(rst)) |-> done)
    else $error("scan ended without a result strobe");

  // the strobe never overlaps a running scan
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe during a scan");

  // a miss reports all-zero route fields
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !hit) |-> (next_gateway == '0 && out_port == '0 && match_slot == '0))
    else $error("miss result carries nonzero fields");

endmodule

// File: rtl/lpr_ctrl.sv
// lookup sequencer: accepts words, drives the slot scan, raises the result strobe
// depends on lpr_pkg
module lpr_ctrl import lpr_pkg::*; #(
  parameter int ROUTE_SLOTS = DEF_ROUTE_SLOTS,
  localparam int SLOT_W     = $clog2(ROUTE_SLOTS)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              op,
  output logic              busy,
  output logic              done,
  output lpr_cmd_t          cmd,
  output logic [SLOT_W-1:0] rd_idx
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(ROUTE_SLOTS - 1);

  state_t state;
  logic   accept;

  assign accept           = start && !busy;
  assign cmd.wr_en        = accept && (op == OP_WRITE);
  assign cmd.start_lookup = accept && (op == OP_LOOKUP);
  assign cmd.rd_en        = (state == ST_SCAN);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      busy   <= 1'b0;
      done   <= 1'b0;
      rd_idx <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (cmd.start_lookup) begin
            state  <= ST_SCAN;
            busy   <= 1'b1;
            rd_idx <= '0;
          end
        end
        ST_SCAN: begin
          if (rd_idx == LAST_IDX) begin
            state <= ST_DRAIN;
          end else begin
            rd_idx <= rd_idx + 1'b1;
          end
        end
        ST_DRAIN: begin
          // last slot is compared this cycle
          state <= ST_IDLE;
          busy  <= 1'b0;
          done  <= 1'b1;
        end
        default: begin
          state <= ST_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule

// File: rtl/lpr_datapath.sv
// route storage, valid flags, per-slot match compare and best-match registers
// depends on lpr_pkg
module lpr_datapath import lpr_pkg::*; #(
  parameter int ROUTE_SLOTS = DEF_ROUTE_SLOTS,
  localparam int SLOT_W     = $clog2(ROUTE_SLOTS)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  lpr_cmd_t                cmd,
  input  logic [SLOT_W-1:0]       rd_idx,
  input  logic [SLOT_FIELD_W-1:0] slot,
  input  logic [ADDR_W-1:0]       route_dest,
  input  logic [ADDR_W-1:0]       route_mask,
  input  logic [ADDR_W-1:0]       route_gateway,
  input  logic [PORT_FIELD_W-1:0] route_port,
  input  logic                    route_enable,
  input  logic [ADDR_W-1:0]       target_addr,
  output logic                    hit,
  output logic [ADDR_W-1:0]       next_gateway,
  output logic [PORT_FIELD_W-1:0] out_port,
  output logic [SLOT_FIELD_W-1:0] match_slot
);

  logic [ADDR_W-1:0]       dest_mem [ROUTE_SLOTS];
  logic [ADDR_W-1:0]       mask_mem [ROUTE_SLOTS];
  logic [ADDR_W-1:0]       gw_mem   [ROUTE_SLOTS];
  logic [PORT_FIELD_W-1:0] port_mem [ROUTE_SLOTS];
  logic [ROUTE_SLOTS-1:0]  valid;

  logic                    slot_ok;
  logic [SLOT_W-1:0]       wr_addr;

  logic [ADDR_W-1:0]       target_q;
  logic [ADDR_W-1:0]       rd_dest;
  logic [ADDR_W-1:0]       rd_mask;
  logic [ADDR_W-1:0]       rd_gw;
  logic [PORT_FIELD_W-1:0] rd_port;
  logic                    rd_vld;
  logic [SLOT_W-1:0]       rd_slot;
  logic                    cmp_en;

  logic                    found;
  logic [ADDR_W-1:0]       best_mask;
  logic [ADDR_W-1:0]       best_gw;
  logic [PORT_FIELD_W-1:0] best_port;
  logic [SLOT_W-1:0]       best_slot;

  logic                    is_match;
  logic                    take;

  // writes past the table end are dropped
  assign slot_ok = ({{(ADDR_W-SLOT_FIELD_W){1'b0}}, slot} < ADDR_W'(ROUTE_SLOTS));
  assign wr_addr = SLOT_W'(slot);

  always_ff @(posedge clk) begin
    if (cmd.wr_en && slot_ok) begin
      dest_mem[wr_addr] <= route_dest;
      mask_mem[wr_addr] <= route_mask;
      gw_mem[wr_addr]   <= route_gateway;
      port_mem[wr_addr] <= route_port;
    end
    if (cmd.rd_en) begin
      rd_dest <= dest_mem[rd_idx];
      rd_mask <= mask_mem[rd_idx];
      rd_gw   <= gw_mem[rd_idx];
      rd_port <= port_mem[rd_idx];
      rd_vld  <= valid[rd_idx];
      rd_slot <= rd_idx;
    end
    if (cmd.start_lookup) begin
      target_q <= target_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      cmp_en <= 1'b0;
    end else begin
      cmp_en <= cmd.rd_en;
      if (cmd.wr_en && slot_ok) begin
        valid[wr_addr] <= route_enable;
      end
    end
  end

  // strictly larger mask replaces, so the lowest slot keeps a tie
  assign is_match = ((rd_mask & rd_dest) == (rd_mask & target_q));
  assign take     = cmp_en && rd_vld && is_match && (!found || (rd_mask > best_mask));

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (cmd.start_lookup) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_lookup) begin
      best_mask <= '0;
      best_gw   <= '0;
      best_port <= '0;
      best_slot <= '0;
    end else if (take) begin
      best_mask <= rd_mask;
      best_gw   <= rd_gw;
      best_port <= rd_port;
      best_slot <= rd_slot;
    end
  end

  assign hit          = found;
  assign next_gateway = best_gw;
  assign out_port     = best_port;
  assign match_slot   = SLOT_FIELD_W'(best_slot);

endmodule

// File: tb/lpr_route_checker.sv
// route table checker: mirrors the route slots, predicts every lookup result
// and compares it with the done word of the lookup block; uses lpr_pkg
module lpr_route_checker import lpr_pkg::*; #(
  parameter int ROUTE_SLOTS = DEF_ROUTE_SLOTS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    busy,
  input  logic                    op,
  input  logic [SLOT_FIELD_W-1:0] slot,
  input  logic [ADDR_W-1:0]       route_dest,
  input  logic [ADDR_W-1:0]       route_mask,
  input  logic [ADDR_W-1:0]       route_gateway,
  input  logic [PORT_FIELD_W-1:0] route_port,
  input  logic                    route_enable,
  input  logic [ADDR_W-1:0]       target_addr,
  input  logic                    done,
  input  logic                    hit,
  input  logic [ADDR_W-1:0]       next_gateway,
  input  logic [PORT_FIELD_W-1:0] out_port,
  input  logic [SLOT_FIELD_W-1:0] match_slot,
  output int                      errors,
  output int                      pending,
  output int                      hits
);

  typedef struct packed {
    logic                    hit;
    logic [ADDR_W-1:0]       gateway;
    logic [PORT_FIELD_W-1:0] port;
    logic [SLOT_FIELD_W-1:0] idx;
  } route_result_t;

  logic [ADDR_W-1:0]       dest_mirror    [ROUTE_SLOTS];
  logic [ADDR_W-1:0]       mask_mirror    [ROUTE_SLOTS];
  logic [ADDR_W-1:0]       gateway_mirror [ROUTE_SLOTS];
  logic [PORT_FIELD_W-1:0] port_mirror    [ROUTE_SLOTS];
  logic [ROUTE_SLOTS-1:0]  slot_valid;

  route_result_t expected_routes[$];

  initial begin
    errors  = 0;
    pending = 0;
    hits    = 0;
  end

  // longest mask among the valid matching slots, lowest index on a tie
  function automatic route_result_t best_route(input logic [ADDR_W-1:0] target);
    route_result_t     res;
    logic [ADDR_W-1:0] longest;
    res     = '0;
    longest = '0;
    for (int i = 0; i < ROUTE_SLOTS; i++) begin
      if (slot_valid[i] && ((mask_mirror[i] & dest_mirror[i]) == (mask_mirror[i] & target))
          && (!res.hit || mask_mirror[i] > longest)) begin
        res.hit     = 1'b1;
        res.gateway = gateway_mirror[i];
        res.port    = port_mirror[i];
        res.idx     = SLOT_FIELD_W'(i);
        longest     = mask_mirror[i];
      end
    end
    return res;
  endfunction

  task automatic check_field(input string name, input logic [ADDR_W-1:0] want,
                             input logic [ADDR_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    route_result_t want;
    if (rst) begin
      slot_valid = '0;
      expected_routes.delete();
    end else begin
      // results first, so a lookup taken in the done cycle queues behind it
      if (done) begin
        if (expected_routes.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual hit=%b gw=%h port=%0d slot=%0d",
                   $time, hit, next_gateway, out_port, match_slot);
          errors++;
        end else begin
          want = expected_routes.pop_front();
          check_field("hit", ADDR_W'(want.hit), ADDR_W'(hit));
          check_field("next_gateway", want.gateway, next_gateway);
          check_field("out_port", ADDR_W'(want.port), ADDR_W'(out_port));
          check_field("match_slot", ADDR_W'(want.idx), ADDR_W'(match_slot));
          if (want.hit) hits++;
        end
      end
      if (start && !busy) begin
        if (op == OP_WRITE) begin
          if (int'(slot) < ROUTE_SLOTS) begin
            dest_mirror[slot]    = route_dest;
            mask_mirror[slot]    = route_mask;
            gateway_mirror[slot] = route_gateway;
            port_mirror[slot]    = route_port;
            slot_valid[slot]     = route_enable;
          end
        end else begin
          expected_routes.push_back(best_route(target_addr));
        end
      end
    end
    pending = expected_routes.size();
  end

endmodule

// File: tb/tb_longest_prefix_route_lookup_top.sv
// testbench top for the longest prefix route lookup: clock, reset, stimulus
// and verdict; depends on lpr_pkg, lpr_route_checker and the block itself
module tb_longest_prefix_route_lookup_top;
  import lpr_pkg::*;

  localparam int SLOTS       = DEF_ROUTE_SLOTS;
  localparam int RANDOM_WORDS = 1250;
  // one lookup keeps the block busy while it scans every slot, result right after
  localparam int DRAIN_CYCLES = SLOTS + 8;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    op = OP_WRITE;
  logic [SLOT_FIELD_W-1:0] slot = '0;
  logic [ADDR_W-1:0]       route_dest = '0;
  logic [ADDR_W-1:0]       route_mask = '0;
  logic [ADDR_W-1:0]       route_gateway = '0;
  logic [PORT_FIELD_W-1:0] route_port = '0;
  logic                    route_enable = 1'b0;
  logic [ADDR_W-1:0]       target_addr = '0;
  logic                    busy;
  logic                    done;
  logic                    hit;
  logic [ADDR_W-1:0]       next_gateway;
  logic [PORT_FIELD_W-1:0] out_port;
  logic [SLOT_FIELD_W-1:0] match_slot;

  int errors;
  int pending;
  int hits;
  int write_words;
  int lookup_words;
  int burst_left;

  // network bases shared by writes and lookups so that prefixes overlap
  logic [ADDR_W-1:0] net_base[6];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  longest_prefix_route_lookup_top #(.ROUTE_SLOTS(SLOTS)) uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op), .slot(slot),
    .route_dest(route_dest), .route_mask(route_mask), .route_gateway(route_gateway),
    .route_port(route_port), .route_enable(route_enable), .target_addr(target_addr),
    .done(done), .hit(hit), .next_gateway(next_gateway), .out_port(out_port),
    .match_slot(match_slot)
  );

  lpr_route_checker #(.ROUTE_SLOTS(SLOTS)) route_check (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op), .slot(slot),
    .route_dest(route_dest), .route_mask(route_mask), .route_gateway(route_gateway),
    .route_port(route_port), .route_enable(route_enable), .target_addr(target_addr),
    .done(done), .hit(hit), .next_gateway(next_gateway), .out_port(out_port),
    .match_slot(match_slot), .errors(errors), .pending(pending), .hits(hits)
  );

  // present one word, hold it until the block takes it, then either chain the
  // next word of the burst straight on or drop start for a random gap
  task automatic send_word(input logic w_op, input logic [SLOT_FIELD_W-1:0] w_slot,
                           input logic [ADDR_W-1:0] w_dest, input logic [ADDR_W-1:0] w_mask,
                           input logic [ADDR_W-1:0] w_gw, input logic [PORT_FIELD_W-1:0] w_port,
                           input logic w_en, input logic [ADDR_W-1:0] w_target);
    op            <= w_op;
    slot          <= w_slot;
    route_dest    <= w_dest;
    route_mask    <= w_mask;
    route_gateway <= w_gw;
    route_port    <= w_port;
    route_enable  <= w_en;
    target_addr   <= w_target;
    start         <= 1'b1;
    // busy sampled before the edge updates it: low means the word went in
    @(posedge clk);
    while (busy) @(posedge clk);
    if (w_op == OP_WRITE) write_words++;
    else lookup_words++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 25)) @(posedge clk);
      // now and then a long stretch with no gaps at all
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(0, 10);
    end
  endtask

  // lookup word: the route fields carry noise the block must ignore
  task automatic send_lookup(input logic [ADDR_W-1:0] target);
    send_word(OP_LOOKUP, SLOT_FIELD_W'($urandom), $urandom, $urandom, $urandom,
              PORT_FIELD_W'($urandom), 1'($urandom), target);
  endtask

  // write word: target field is noise here
  task automatic send_route(input logic [SLOT_FIELD_W-1:0] s, input logic [ADDR_W-1:0] d,
                            input logic [ADDR_W-1:0] m, input logic [ADDR_W-1:0] g,
                            input logic [PORT_FIELD_W-1:0] p, input logic en);
    send_word(OP_WRITE, s, d, m, g, p, en, $urandom);
  endtask

  function automatic logic [ADDR_W-1:0] prefix_mask(input int len);
    return (len == 0) ? '0 : ~(ADDR_W'(0)) << (ADDR_W - len);
  endfunction

  initial begin
    logic [ADDR_W-1:0] m;
    logic [ADDR_W-1:0] base;
    write_words  = 0;
    lookup_words = 0;
    burst_left   = $urandom_range(0, 10);
    net_base[0]  = '0;
    net_base[1]  = '1;
    for (int i = 2; i < 6; i++) net_base[i] = $urandom;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed part ---
    // empty table misses at both address extremes
    send_lookup('0);
    send_lookup('1);
    // default route with zero mask catches everything
    send_route(4'd0, '0, '0, 32'h0a00_0001, 3'd1, 1'b1);
    send_lookup(32'hc0a8_0101);
    // host route in the top slot, all fields at their maximum
    send_route(4'd15, '1, '1, '1, 3'd7, 1'b1);
    send_lookup('1);
    send_lookup(32'hffff_fffe);
    // equal masks on two matching slots: lower index must win
    send_route(4'd3, 32'hc0a8_0000, 32'hffff_0000, 32'h0000_0003, 3'd3, 1'b1);
    send_route(4'd5, 32'hc0a8_ffff, 32'hffff_0000, 32'h0000_0005, 3'd5, 1'b1);
    send_lookup(32'hc0a8_1234);
    // a later zero mask does not displace the earlier one
    send_route(4'd2, '0, '0, 32'h0000_0002, 3'd2, 1'b1);
    send_lookup(32'h0102_0304);
    // non-contiguous mask taken at face value
    send_route(4'd7, 32'hc0a8_0100, 32'hff00_ff00, 32'h0000_0007, 3'd6, 1'b1);
    send_lookup(32'hc0ff_01aa);
    // removing routes hands the match on to the next candidate
    send_route(4'd3, 32'h1111_1111, 32'h2222_2222, 32'h3333_3333, 3'd4, 1'b0);
    send_lookup(32'hc0a8_1234);
    send_route(4'd0, '0, '0, '0, 3'd0, 1'b0);
    send_lookup(32'h0102_0304);
    send_route(4'd15, '1, '1, '1, 3'd7, 1'b0);
    send_lookup('1);
    // all-zero gateway and port on a hit
    send_route(4'd9, 32'h1234_5678, '1, '0, 3'd0, 1'b1);
    send_lookup(32'h1234_5678);

    // --- random part: overlapping prefixes so that hits dominate ---
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      base = net_base[$urandom_range(0, 5)];
      if ($urandom_range(0, 99) < 35) begin
        m = ($urandom_range(0, 9) == 0) ? $urandom : prefix_mask($urandom_range(0, 32));
        send_route(SLOT_FIELD_W'($urandom),
                   ($urandom_range(0, 9) == 0) ? $urandom : ((base & m) | ($urandom & ~m)),
                   m, $urandom, PORT_FIELD_W'($urandom), $urandom_range(0, 99) < 85);
      end else if ($urandom_range(0, 99) < 15) begin
        send_lookup($urandom);
      end else begin
        // flip only a random number of low bits of a known network
        send_lookup(base ^ ($urandom >> $urandom_range(0, 32)));
      end
    end

    // let every lookup come back, then watch for stray results
    start <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d route writes and %0d lookups, %0d of the lookups hit",
             write_words, lookup_words, hits);
    if (errors == 0 && pending == 0) begin
      $display("longest_prefix_route_lookup_top verification clean");
    end else begin
      $display("longest_prefix_route_lookup_top verification failed");
    end
    $finish;
  end

  // watchdog, far beyond a run of nothing but lookups with the longest gaps
  initial begin
    #30_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("longest_prefix_route_lookup_top verification failed");
    $finish;
  end

endmodule

// File: longest_prefix_route_lookup_top.f
rtl/lpr_pkg.sv
rtl/lpr_ctrl.sv
rtl/lpr_datapath.sv
rtl/longest_prefix_route_lookup_top.sv
tb/lpr_route_checker.sv
tb/tb_longest_prefix_route_lookup_top.sv
